@@ rtl/core/csvp_pkg.sv @@
// ----------------------------------------------------------------------------
// csvp_pkg
// Shared codes, types and character helpers for the CSV integer field parser.
// ----------------------------------------------------------------------------
package csvp_pkg;

  // parse phases
  localparam logic [2:0] PH_LEAD  = 3'd0;
  localparam logic [2:0] PH_SIGN  = 3'd1;
  localparam logic [2:0] PH_ZERO  = 3'd2;
  localparam logic [2:0] PH_DEC   = 3'd3;
  localparam logic [2:0] PH_HEX   = 3'd4;
  localparam logic [2:0] PH_TRAIL = 3'd5;
  localparam logic [2:0] PH_DRAIN = 3'd6;

  // result status codes
  localparam logic [2:0] ST_OK_COMMA = 3'd0;
  localparam logic [2:0] ST_OK_END   = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_BAD      = 3'd3;
  localparam logic [2:0] ST_END_FAIL = 3'd4;

  // characters of interest
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_X_LO  = 8'h78;

  // per-field parse state
  typedef struct packed {
    logic [2:0]  phase;
    logic [31:0] acc;
    logic        neg;
  } parse_state_t;

  // what one byte produces
  typedef struct packed {
    logic        emit;
    logic [31:0] value;
    logic [2:0]  status;
  } parse_result_t;

  localparam parse_state_t STATE_RESET = '{phase: PH_LEAD, acc: 32'd0, neg: 1'b0};

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= 8'd48) && (c <= 8'd57);
  endfunction

  function automatic logic is_hex_letter(input logic [7:0] c);
    return (c >= 8'd65 && c <= 8'd70) || (c >= 8'd97 && c <= 8'd102);
  endfunction

endpackage

@@ rtl/core/csvp_step.sv @@
// ----------------------------------------------------------------------------
// csvp_step
// Next-state and result logic for one text byte of the field parser.
// ----------------------------------------------------------------------------
module csvp_step (
  input  logic [7:0]             char_in,
  input  csvp_pkg::parse_state_t cur,
  output csvp_pkg::parse_state_t nxt,
  output csvp_pkg::parse_result_t res
);
  import csvp_pkg::*;

  logic        ws, dig, hexd, nul;
  logic [3:0]  hv;
  logic [31:0] sval, acc_dec, acc_hex;
  logic        do_start, do_dec, do_trail;

  // character classes and candidate accumulator values
  assign ws      = is_ws(char_in);
  assign dig     = is_dig(char_in);
  assign hexd    = dig || is_hex_letter(char_in);
  assign nul     = (char_in == CH_NUL);
  // letters A-F / a-f carry value (low nibble + 9)
  assign hv      = dig ? char_in[3:0] : (char_in[3:0] + 4'd9);
  assign acc_dec = {cur.acc[28:0], 3'b000} + {cur.acc[30:0], 1'b0} + {28'd0, char_in[3:0]};
  assign acc_hex = {cur.acc[27:0], hv};
  assign sval    = cur.neg ? (32'd0 - cur.acc) : cur.acc;

  always_comb begin
    nxt      = cur;
    res      = '{emit: 1'b0, value: 32'd0, status: ST_OK_COMMA};
    do_start = 1'b0;
    do_dec   = 1'b0;
    do_trail = 1'b0;

    // phase dispatch
    unique case (cur.phase)
      PH_SIGN: do_start = 1'b1;
      PH_ZERO: begin
        if (char_in == CH_X_LO || char_in == CH_X_UP) nxt.phase = PH_HEX;
        else do_dec = 1'b1;
      end
      PH_DEC: do_dec = 1'b1;
      PH_HEX: begin
        if (hexd) nxt.acc = acc_hex;
        else do_trail = 1'b1;
      end
      PH_TRAIL: do_trail = 1'b1;
      PH_DRAIN: begin
        if (nul) begin
          nxt = STATE_RESET;
          res = '{emit: 1'b1, value: 32'd0, status: ST_END_FAIL};
        end
      end
      default: begin
        // leading whitespace; unused code lands here too
        nxt.phase = PH_LEAD;
        if (ws) begin
          nxt.phase = PH_LEAD;
        end else if (char_in == CH_MINUS) begin
          nxt.neg   = 1'b1;
          nxt.phase = PH_SIGN;
        end else begin
          do_start = 1'b1;
        end
      end
    endcase

    // first byte after the optional sign
    if (do_start) begin
      if (nul) begin
        nxt = STATE_RESET;
        res = '{emit: 1'b1, value: 32'd0, status: ST_EMPTY};
      end else if (char_in == CH_ZERO) begin
        nxt.phase = PH_ZERO;
      end else begin
        do_dec = 1'b1;
      end
    end

    // decimal digit accumulation
    if (do_dec) begin
      if (dig) begin
        nxt.acc   = acc_dec;
        nxt.phase = PH_DEC;
      end else begin
        do_trail = 1'b1;
      end
    end

    // byte after the number part
    if (do_trail) begin
      if (ws) begin
        nxt.phase = PH_TRAIL;
      end else if (char_in == CH_COMMA) begin
        nxt = STATE_RESET;
        res = '{emit: 1'b1, value: sval, status: ST_OK_COMMA};
      end else if (nul) begin
        nxt = STATE_RESET;
        res = '{emit: 1'b1, value: sval, status: ST_OK_END};
      end else begin
        nxt.phase = PH_DRAIN;
        res = '{emit: 1'b1, value: sval, status: ST_BAD};
      end
    end
  end

endmodule

@@ rtl/core/csv_integer_field_parser_unit.sv @@
// ----------------------------------------------------------------------------
// csv_integer_field_parser_unit
// Parses comma-separated signed decimal / hex integers from a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: char_in with char_valid / char_stall. One text byte per
//   request; byte 0 ends the string. A byte is taken when char_valid is high
//   and char_stall is low.
//   Output channel: value / status with result_valid / result_stall. One
//   result request per comma, terminator or bad character (in the drain
//   phase, per terminator only); other bytes produce nothing.
//   Result path: an accepted byte lands in the input register, and the
//   parse logic then loads the result register from it (see Stall for
//   when a byte waits there).
//   Throughput: one byte per cycle while char_stall is low. The parse step is a single pass over the
//   registered byte and the field state (one 32-bit multiply-by-10 add).
//   Stall: while result_stall holds a result, bytes that produce no result
//   keep flowing; a byte that would produce one waits in the input register
//   and raises char_stall until the result register frees up.
//   Reset (rst, synchronous): both channels empty, field state cleared to
//   the leading-whitespace phase.
// ----------------------------------------------------------------------------
module csv_integer_field_parser_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               char_valid,
  output logic               char_stall,
  input  logic [7:0]         char_in,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] value,
  output logic [2:0]         status
);
  import csvp_pkg::*;

  logic          s1_valid;
  logic [7:0]    s1_char;
  parse_state_t  pstate, pstate_next;
  parse_result_t res;
  logic          out_free, s1_go, char_fire;

  // per-byte parse logic
  csvp_step u_step (
    .char_in (s1_char),
    .cur     (pstate),
    .nxt     (pstate_next),
    .res     (res)
  );

  // handshake
  assign out_free   = !result_valid || !result_stall;
  assign s1_go      = s1_valid && (!res.emit || out_free);
  assign char_stall = s1_valid && !s1_go;
  assign char_fire  = char_valid && !char_stall;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      pstate       <= STATE_RESET;
    end else begin
      if (s1_go) pstate <= pstate_next;
      if (char_fire) s1_valid <= 1'b1;
      else if (s1_go) s1_valid <= 1'b0;
      if (s1_go && res.emit) result_valid <= 1'b1;
      else if (!result_stall) result_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (char_fire) s1_char <= char_in;
    if (s1_go && res.emit) begin
      value  <= res.value;
      status <= res.status;
    end
  end

`ifndef SYNTH
  // a clean field end returns the field state to reset
  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    (s1_go && res.emit && res.status != ST_BAD) |=>
      (pstate.phase == PH_LEAD && pstate.acc == 32'd0 && !pstate.neg))
    else $error("field state not cleared after result");

  // a bad character moves to drain
  a_bad_drains: assert property (@(posedge clk) disable iff (rst)
    (s1_go && res.emit && res.status == ST_BAD) |=> (pstate.phase == PH_DRAIN))
    else $error("bad character did not enter drain");

  // while draining, only the terminator reports
  a_drain_result: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && pstate.phase == PH_DRAIN && res.emit) |->
      (res.status == ST_END_FAIL && s1_char == CH_NUL))
    else $error("unexpected result while draining");

  // the sign flag never survives into the leading phase
  a_neg_phase: assert property (@(posedge clk) disable iff (rst)
    pstate.neg |-> (pstate.phase != PH_LEAD))
    else $error("sign set in leading phase");

  // a waiting byte only stalls when it has a result to deliver
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    char_stall |-> (res.emit && result_valid && result_stall))
    else $error("input stalled without a blocked result");
`endif

endmodule
